// ===== rtl/cse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the counting sort engine.
// No dependencies; every other file of the block uses it.
package cse_pkg;

    localparam int KEY_BITS_DEF  = 8;
    localparam int MAX_ITEMS_DEF = 64;
    localparam int KEY_W         = 8;
    localparam int CNT_W         = 7;

    typedef logic [3:0] t_op;

    localparam t_op OP_CLEAR    = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_LOAD_WR  = 4'd2;
    localparam t_op OP_SUM      = 4'd3;
    localparam t_op OP_SUM_LAST = 4'd4;
    localparam t_op OP_PL_KEY   = 4'd5;
    localparam t_op OP_PL_HIST  = 4'd6;
    localparam t_op OP_PL_WR    = 4'd7;
    localparam t_op OP_EM_RD    = 4'd8;
    localparam t_op OP_EM_OUT   = 4'd9;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } t_in_beat;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic             end_of_run;
        logic             overflow;
    } t_out_beat;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic last_q;
        logic sweep_end;
        logic place_end;
        logic emit_end;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/cse_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the counting sort engine: valid, ready and one key beat.
// Depends on cse_pkg.
interface cse_in_if;
    logic                valid;
    logic                ready;
    cse_pkg::t_in_beat   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cse_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the counting sort engine: valid, ready and one sorted beat.
// Depends on cse_pkg.
interface cse_out_if;
    logic                valid;
    logic                ready;
    cse_pkg::t_out_beat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cse_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the counting sort engine: histogram, key and sorted memories,
// sweep and item counters, output register. Depends on cse_pkg and the channel interfaces.
module cse_dp #(
    parameter int KEY_BITS  = cse_pkg::KEY_BITS_DEF,
    parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  cse_pkg::t_cmd   i_cmd,
    output cse_pkg::t_stat  o_stat,
    cse_in_if.sink          i_in,
    cse_out_if.source       o_out
);
    localparam int HD = 1 << KEY_BITS;
    localparam int IB = $clog2(MAX_ITEMS);
    localparam int CB = $clog2(MAX_ITEMS + 1);
    localparam int CW = cse_pkg::CNT_W;
    localparam int KW = cse_pkg::KEY_W;

    logic [CW-1:0]       mem_hist [HD];
    logic [KEY_BITS-1:0] mem_key [MAX_ITEMS];
    logic [KEY_BITS-1:0] mem_sorted [MAX_ITEMS];

    logic                r_descending;
    logic [CB-1:0]       r_fill;
    logic                r_dropped;
    logic [KEY_BITS-1:0] r_hidx;
    logic                r_sv;
    logic [KEY_BITS-1:0] r_waddr;
    logic [CW-1:0]       r_sum;
    logic [KEY_BITS-1:0] r_key_l;
    logic                r_last;
    logic                r_store;
    logic [CB-1:0]       r_pidx;
    logic [CB-1:0]       r_eidx;
    logic [CW-1:0]       r_hist_q;
    logic [KEY_BITS-1:0] r_key_q;
    logic [KEY_BITS-1:0] r_sorted_q;
    logic                r_ov;
    cse_pkg::t_out_beat  r_out;

    logic [KEY_BITS-1:0] w_in_key;
    logic [KEY_BITS-1:0] w_sum_addr;
    logic                w_accept;
    logic                w_room;
    logic [KEY_BITS-1:0] w_hraddr;
    logic                w_hwe;
    logic [KEY_BITS-1:0] w_hwaddr;
    logic [CW-1:0]       w_hwdata;
    logic [CW-1:0]       w_pos;
    logic [CW-1:0]       w_sum_next;
    logic                w_free;
    logic                w_emit;
    logic                w_emit_end;
    logic [CB-1:0]       w_eidx_inc;

    assign w_in_key   = KEY_BITS'(i_in.data.key);
    assign w_sum_addr = r_descending ? ~r_hidx : r_hidx;
    assign i_in.ready = (i_cmd.op == cse_pkg::OP_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_room     = (r_fill < CB'(MAX_ITEMS));
    assign w_pos      = r_hist_q - CW'(1);
    assign w_sum_next = r_sum + r_hist_q;
    assign w_free     = !r_ov || o_out.ready;
    assign w_eidx_inc = r_eidx + CB'(1);
    assign w_emit_end = (w_eidx_inc == r_fill);
    assign w_emit     = (i_cmd.op == cse_pkg::OP_EM_OUT) && w_free;

    always_comb begin
        w_hraddr = r_key_q;
        w_hwe    = 1'b0;
        w_hwaddr = r_key_q;
        w_hwdata = w_pos;
        case (i_cmd.op)
            cse_pkg::OP_CLEAR: begin
                w_hwe    = 1'b1;
                w_hwaddr = r_hidx;
                w_hwdata = '0;
            end
            cse_pkg::OP_LOAD: begin
                w_hraddr = w_in_key;
            end
            cse_pkg::OP_LOAD_WR: begin
                w_hwe    = r_store;
                w_hwaddr = r_key_l;
                w_hwdata = r_hist_q + CW'(1);
            end
            cse_pkg::OP_SUM, cse_pkg::OP_SUM_LAST: begin
                w_hraddr = w_sum_addr;
                w_hwe    = r_sv;
                w_hwaddr = r_waddr;
                w_hwdata = w_sum_next;
            end
            cse_pkg::OP_PL_WR: begin
                w_hwe = 1'b1;
            end
            default: begin
                w_hwe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            mem_hist[w_hwaddr] <= w_hwdata;
        end
        r_hist_q <= mem_hist[w_hraddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            mem_key[IB'(r_fill)] <= w_in_key;
        end
        if (i_cmd.op == cse_pkg::OP_PL_KEY) begin
            r_key_q <= mem_key[IB'(r_pidx - CB'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == cse_pkg::OP_PL_WR) && (w_pos < CW'(MAX_ITEMS))) begin
            mem_sorted[IB'(w_pos)] <= r_key_q;
        end
        if (i_cmd.op == cse_pkg::OP_EM_RD) begin
            r_sorted_q <= mem_sorted[IB'(r_eidx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key_l <= w_in_key;
            r_last  <= i_in.data.last;
            r_store <= w_room;
        end
        if (i_cmd.op == cse_pkg::OP_SUM) begin
            r_waddr <= w_sum_addr;
        end
        if (w_emit) begin
            r_out.sorted_key <= KW'(r_sorted_q);
            r_out.end_of_run <= w_emit_end;
            r_out.overflow   <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
            r_fill       <= '0;
            r_dropped    <= 1'b0;
            r_hidx       <= '0;
            r_sv         <= 1'b0;
            r_sum        <= '0;
            r_pidx       <= '0;
            r_eidx       <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_descending <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (w_room) begin
                    r_fill <= r_fill + CB'(1);
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.op inside {cse_pkg::OP_CLEAR, cse_pkg::OP_SUM}) begin
                r_hidx <= r_hidx + KEY_BITS'(1);
            end
            r_sv <= (i_cmd.op == cse_pkg::OP_SUM);
            if (r_sv && (i_cmd.op == cse_pkg::OP_SUM)) begin
                r_sum <= w_sum_next;
            end
            if (i_cmd.op == cse_pkg::OP_SUM_LAST) begin
                r_sum  <= '0;
                r_pidx <= r_fill;
                r_eidx <= '0;
            end
            if (i_cmd.op == cse_pkg::OP_PL_WR) begin
                r_pidx <= r_pidx - CB'(1);
            end
            if (w_emit) begin
                r_eidx <= w_eidx_inc;
                if (w_emit_end) begin
                    r_fill    <= '0;
                    r_dropped <= 1'b0;
                end
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign o_stat.accept    = w_accept;
    assign o_stat.last_q    = r_last;
    assign o_stat.sweep_end = (r_hidx == {KEY_BITS{1'b1}});
    assign o_stat.place_end = (r_pidx == CB'(1));
    assign o_stat.emit_end  = w_emit_end;
    assign o_stat.out_free  = w_free;

endmodule

// ===== rtl/cse_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the counting sort engine: sequences clear, load, prefix sum,
// placement and emission. Depends on cse_pkg.
module cse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cse_pkg::t_stat  i_stat,
    output cse_pkg::t_cmd   o_cmd
);
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_LOAD_WR  = 4'd2;
    localparam logic [3:0] S_SUM      = 4'd3;
    localparam logic [3:0] S_SUM_LAST = 4'd4;
    localparam logic [3:0] S_PL_KEY   = 4'd5;
    localparam logic [3:0] S_PL_HIST  = 4'd6;
    localparam logic [3:0] S_PL_WR    = 4'd7;
    localparam logic [3:0] S_EM_RD    = 4'd8;
    localparam logic [3:0] S_EM_OUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.op = cse_pkg::OP_CLEAR;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = cse_pkg::OP_CLEAR;
                if (i_stat.sweep_end) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op = cse_pkg::OP_LOAD;
                if (i_stat.accept) begin
                    n_state = S_LOAD_WR;
                end
            end
            S_LOAD_WR: begin
                o_cmd.op = cse_pkg::OP_LOAD_WR;
                n_state  = i_stat.last_q ? S_SUM : S_LOAD;
            end
            S_SUM: begin
                o_cmd.op = cse_pkg::OP_SUM;
                if (i_stat.sweep_end) begin
                    n_state = S_SUM_LAST;
                end
            end
            S_SUM_LAST: begin
                o_cmd.op = cse_pkg::OP_SUM_LAST;
                n_state  = S_PL_KEY;
            end
            S_PL_KEY: begin
                o_cmd.op = cse_pkg::OP_PL_KEY;
                n_state  = S_PL_HIST;
            end
            S_PL_HIST: begin
                o_cmd.op = cse_pkg::OP_PL_HIST;
                n_state  = S_PL_WR;
            end
            S_PL_WR: begin
                o_cmd.op = cse_pkg::OP_PL_WR;
                n_state  = i_stat.place_end ? S_EM_RD : S_PL_KEY;
            end
            S_EM_RD: begin
                o_cmd.op = cse_pkg::OP_EM_RD;
                n_state  = S_EM_OUT;
            end
            S_EM_OUT: begin
                o_cmd.op = cse_pkg::OP_EM_OUT;
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_end ? S_CLEAR : S_EM_RD;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/counting_sort_engine.sv =====
`timescale 1ns / 1ps
// Counting sort engine. Keys are taken one beat at a time, load then write, into
// a key buffer of MAX_ITEMS entries while a histogram of 2^KEY_BITS counts is updated;
// keys beyond MAX_ITEMS are dropped and every result of that run carries overflow.
// The beat marked last starts the sort: a prefix pass over the histogram, then each key
// placed (key read, histogram read, write), then each sorted beat read and sent out,
// held while the output is not taken, with end_of_run on the final one. After each run,
// and after reset, the histogram is swept clear; no key is accepted during the sweep.
// Write the descending bit only while the engine is idle.
module counting_sort_engine #(
    parameter int KEY_BITS  = cse_pkg::KEY_BITS_DEF,
    parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    cse_in_if.sink     i_in,
    cse_out_if.source  o_out
);
    cse_pkg::t_cmd  w_cmd;
    cse_pkg::t_stat w_stat;

    cse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cse_dp #(
        .KEY_BITS  (KEY_BITS),
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule
